FILE: hdl/ecsm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the control program of the small-curve signer.
// No dependencies; every other file imports this package.
package ecsm_pkg;

	localparam int FIELD_BITS_DEF = 16;
	localparam int IO_W           = 16;
	localparam int CFG_IW         = 2;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_CURVE_A     = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_FIELD_PRIME = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_GROUP_ORDER = 2'd2;

	typedef struct packed {
		logic [IO_W-1:0] point_x;
		logic [IO_W-1:0] point_y;
		logic [IO_W-1:0] private_key;
		logic [IO_W-1:0] message;
		logic [IO_W-1:0] nonce;
	} in_req_t;

	typedef struct packed {
		logic [IO_W-1:0] sig_r;
		logic [IO_W-1:0] sig_s;
	} out_rsp_t;

	// micro-operations
	localparam logic [4:0] OP_NOP  = 5'd0;
	localparam logic [4:0] OP_LDI  = 5'd1;
	localparam logic [4:0] OP_LDK  = 5'd2;
	localparam logic [4:0] OP_ADD  = 5'd3;
	localparam logic [4:0] OP_SUB  = 5'd4;
	localparam logic [4:0] OP_MUL  = 5'd5;
	localparam logic [4:0] OP_MOD  = 5'd6;
	localparam logic [4:0] OP_INV  = 5'd7;
	localparam logic [4:0] OP_MOV  = 5'd8;
	localparam logic [4:0] OP_SETAI = 5'd9;
	localparam logic [4:0] OP_SETRI = 5'd10;
	localparam logic [4:0] OP_CPRI = 5'd11;
	localparam logic [4:0] OP_CCLR = 5'd12;
	localparam logic [4:0] OP_CINC = 5'd13;
	localparam logic [4:0] OP_LDA  = 5'd14;
	localparam logic [4:0] OP_QM1  = 5'd15;
	localparam logic [4:0] OP_DONE = 5'd16;

	// jump conditions
	localparam logic [3:0] C_NONE    = 4'd0;
	localparam logic [3:0] C_ALW     = 4'd1;
	localparam logic [3:0] C_BIT0    = 4'd2;
	localparam logic [3:0] C_AINF    = 4'd3;
	localparam logic [3:0] C_RINF    = 4'd4;
	localparam logic [3:0] C_NE      = 4'd5;
	localparam logic [3:0] C_EQZ     = 4'd6;
	localparam logic [3:0] C_NOTLAST = 4'd7;
	localparam logic [3:0] C_BADMOD  = 4'd8;

	// modulus select
	localparam logic MS_P = 1'b0;
	localparam logic MS_Q = 1'b1;

	// input field select for OP_LDI
	localparam logic [3:0] IN_X     = 4'd0;
	localparam logic [3:0] IN_Y     = 4'd1;
	localparam logic [3:0] IN_KEY   = 4'd2;
	localparam logic [3:0] IN_MSG   = 4'd3;
	localparam logic [3:0] IN_NONCE = 4'd4;

	// register file slots
	localparam logic [3:0] R_AX   = 4'd0;
	localparam logic [3:0] R_AY   = 4'd1;
	localparam logic [3:0] R_RX   = 4'd2;
	localparam logic [3:0] R_RY   = 4'd3;
	localparam logic [3:0] R_K    = 4'd4;
	localparam logic [3:0] R_KEY  = 4'd5;
	localparam logic [3:0] R_MSG  = 4'd6;
	localparam logic [3:0] R_CA   = 4'd7;
	localparam logic [3:0] R_T0   = 4'd8;
	localparam logic [3:0] R_T1   = 4'd9;
	localparam logic [3:0] R_T2   = 4'd10;
	localparam logic [3:0] R_SL   = 4'd11;
	localparam logic [3:0] R_H    = 4'd12;
	localparam logic [3:0] R_R    = 4'd13;
	localparam logic [3:0] R_S    = 4'd14;
	localparam logic [3:0] R_BASE = 4'd15;
	localparam int RF_AW = 4;

	localparam int UC_AW = 7;
	localparam logic [UC_AW-1:0] UC_LAST = 7'd84;

	// program labels
	localparam logic [UC_AW-1:0] L_LOOP  = 7'd14;
	localparam logic [UC_AW-1:0] L_GEN   = 7'd30;
	localparam logic [UC_AW-1:0] L_AFIN  = 7'd37;
	localparam logic [UC_AW-1:0] L_COPY  = 7'd42;
	localparam logic [UC_AW-1:0] L_ASI   = 7'd45;
	localparam logic [UC_AW-1:0] L_DBL   = 7'd46;
	localparam logic [UC_AW-1:0] L_RSI   = 7'd62;
	localparam logic [UC_AW-1:0] L_NEXT  = 7'd63;
	localparam logic [UC_AW-1:0] L_RINF  = 7'd67;
	localparam logic [UC_AW-1:0] L_HASH  = 7'd68;
	localparam logic [UC_AW-1:0] L_PW    = 7'd72;
	localparam logic [UC_AW-1:0] L_SQ    = 7'd74;
	localparam logic [UC_AW-1:0] L_ZERO  = 7'd82;

	typedef struct packed {
		logic [4:0]       op;
		logic [3:0]       dst;
		logic [3:0]       sa;
		logic [3:0]       sb;
		logic             msel;
		logic [3:0]       cond;
		logic [UC_AW-1:0] tgt;
	} uc_t;

	function automatic uc_t mk(input logic [4:0] op, input logic [3:0] dst,
		input logic [3:0] sa, input logic [3:0] sb, input logic msel,
		input logic [3:0] cond, input logic [UC_AW-1:0] tgt);
		uc_t w;
		w.op = op; w.dst = dst; w.sa = sa; w.sb = sb;
		w.msel = msel; w.cond = cond; w.tgt = tgt;
		return w;
	endfunction

	localparam logic [UC_AW-1:0] NT = '0;

	function automatic uc_t ucode(input logic [UC_AW-1:0] pc);
		uc_t w;
		case (pc)
			// setup
			7'd0:  w = mk(OP_NOP, R_T0, R_T0, R_T0, MS_P, C_BADMOD, L_ZERO);
			7'd1:  w = mk(OP_LDI, R_RX, IN_X, R_T0, MS_P, C_NONE, NT);
			7'd2:  w = mk(OP_MOD, R_RX, R_RX, R_RX, MS_P, C_NONE, NT);
			7'd3:  w = mk(OP_LDI, R_RY, IN_Y, R_T0, MS_P, C_NONE, NT);
			7'd4:  w = mk(OP_MOD, R_RY, R_RY, R_RY, MS_P, C_NONE, NT);
			7'd5:  w = mk(OP_LDI, R_K, IN_NONCE, R_T0, MS_P, C_NONE, NT);
			7'd6:  w = mk(OP_LDI, R_KEY, IN_KEY, R_T0, MS_P, C_NONE, NT);
			7'd7:  w = mk(OP_MOD, R_KEY, R_KEY, R_KEY, MS_Q, C_NONE, NT);
			7'd8:  w = mk(OP_LDI, R_MSG, IN_MSG, R_T0, MS_P, C_NONE, NT);
			7'd9:  w = mk(OP_LDA, R_CA, R_T0, R_T0, MS_P, C_NONE, NT);
			7'd10: w = mk(OP_MOD, R_CA, R_CA, R_CA, MS_P, C_NONE, NT);
			7'd11: w = mk(OP_SETAI, R_T0, 4'd1, R_T0, MS_P, C_NONE, NT);
			7'd12: w = mk(OP_SETRI, R_T0, 4'd0, R_T0, MS_P, C_NONE, NT);
			7'd13: w = mk(OP_CCLR, R_T0, R_T0, R_T0, MS_P, C_NONE, NT);
			// scalar loop: acc += run when the nonce bit is set
			7'd14: w = mk(OP_NOP, R_T0, R_K, R_T0, MS_P, C_BIT0, L_DBL);
			7'd15: w = mk(OP_NOP, R_T0, R_T0, R_T0, MS_P, C_AINF, L_COPY);
			7'd16: w = mk(OP_NOP, R_T0, R_T0, R_T0, MS_P, C_RINF, L_DBL);
			7'd17: w = mk(OP_NOP, R_T0, R_AX, R_RX, MS_P, C_NE, L_GEN);
			7'd18: w = mk(OP_NOP, R_T0, R_AY, R_RY, MS_P, C_NE, L_ASI);
			7'd19: w = mk(OP_ADD, R_T0, R_AY, R_AY, MS_P, C_NONE, NT);
			7'd20: w = mk(OP_NOP, R_T0, R_T0, R_T0, MS_P, C_EQZ, L_ASI);
			7'd21: w = mk(OP_MUL, R_T1, R_AX, R_AX, MS_P, C_NONE, NT);
			7'd22: w = mk(OP_ADD, R_T2, R_T1, R_T1, MS_P, C_NONE, NT);
			7'd23: w = mk(OP_ADD, R_T1, R_T2, R_T1, MS_P, C_NONE, NT);
			7'd24: w = mk(OP_ADD, R_T1, R_T1, R_CA, MS_P, C_NONE, NT);
			7'd25: w = mk(OP_INV, R_T0, R_T0, R_T0, MS_P, C_NONE, NT);
			7'd26: w = mk(OP_MUL, R_SL, R_T1, R_T0, MS_P, C_NONE, NT);
			7'd27: w = mk(OP_MUL, R_T1, R_SL, R_SL, MS_P, C_NONE, NT);
			7'd28: w = mk(OP_ADD, R_T2, R_AX, R_AX, MS_P, C_NONE, NT);
			7'd29: w = mk(OP_SUB, R_T2, R_T1, R_T2, MS_P, C_ALW, L_AFIN);
			7'd30: w = mk(OP_SUB, R_T0, R_RY, R_AY, MS_P, C_NONE, NT);
			7'd31: w = mk(OP_SUB, R_T1, R_RX, R_AX, MS_P, C_NONE, NT);
			7'd32: w = mk(OP_INV, R_T1, R_T1, R_T1, MS_P, C_NONE, NT);
			7'd33: w = mk(OP_MUL, R_SL, R_T0, R_T1, MS_P, C_NONE, NT);
			7'd34: w = mk(OP_MUL, R_T1, R_SL, R_SL, MS_P, C_NONE, NT);
			7'd35: w = mk(OP_SUB, R_T1, R_T1, R_AX, MS_P, C_NONE, NT);
			7'd36: w = mk(OP_SUB, R_T2, R_T1, R_RX, MS_P, C_NONE, NT);
			7'd37: w = mk(OP_SUB, R_T0, R_AX, R_T2, MS_P, C_NONE, NT);
			7'd38: w = mk(OP_MUL, R_T0, R_SL, R_T0, MS_P, C_NONE, NT);
			7'd39: w = mk(OP_SUB, R_AY, R_T0, R_AY, MS_P, C_NONE, NT);
			7'd40: w = mk(OP_MOV, R_AX, R_T2, R_T0, MS_P, C_NONE, NT);
			7'd41: w = mk(OP_SETAI, R_T0, 4'd0, R_T0, MS_P, C_ALW, L_DBL);
			7'd42: w = mk(OP_MOV, R_AX, R_RX, R_T0, MS_P, C_NONE, NT);
			7'd43: w = mk(OP_MOV, R_AY, R_RY, R_T0, MS_P, C_NONE, NT);
			7'd44: w = mk(OP_CPRI, R_T0, R_T0, R_T0, MS_P, C_ALW, L_DBL);
			7'd45: w = mk(OP_SETAI, R_T0, 4'd1, R_T0, MS_P, C_NONE, NT);
			// run = 2 * run
			7'd46: w = mk(OP_NOP, R_T0, R_T0, R_T0, MS_P, C_RINF, L_NEXT);
			7'd47: w = mk(OP_ADD, R_T0, R_RY, R_RY, MS_P, C_NONE, NT);
			7'd48: w = mk(OP_NOP, R_T0, R_T0, R_T0, MS_P, C_EQZ, L_RSI);
			7'd49: w = mk(OP_MUL, R_T1, R_RX, R_RX, MS_P, C_NONE, NT);
			7'd50: w = mk(OP_ADD, R_T2, R_T1, R_T1, MS_P, C_NONE, NT);
			7'd51: w = mk(OP_ADD, R_T1, R_T2, R_T1, MS_P, C_NONE, NT);
			7'd52: w = mk(OP_ADD, R_T1, R_T1, R_CA, MS_P, C_NONE, NT);
			7'd53: w = mk(OP_INV, R_T0, R_T0, R_T0, MS_P, C_NONE, NT);
			7'd54: w = mk(OP_MUL, R_SL, R_T1, R_T0, MS_P, C_NONE, NT);
			7'd55: w = mk(OP_MUL, R_T1, R_SL, R_SL, MS_P, C_NONE, NT);
			7'd56: w = mk(OP_ADD, R_T2, R_RX, R_RX, MS_P, C_NONE, NT);
			7'd57: w = mk(OP_SUB, R_T2, R_T1, R_T2, MS_P, C_NONE, NT);
			7'd58: w = mk(OP_SUB, R_T0, R_RX, R_T2, MS_P, C_NONE, NT);
			7'd59: w = mk(OP_MUL, R_T0, R_SL, R_T0, MS_P, C_NONE, NT);
			7'd60: w = mk(OP_SUB, R_RY, R_T0, R_RY, MS_P, C_NONE, NT);
			7'd61: w = mk(OP_MOV, R_RX, R_T2, R_T0, MS_P, C_ALW, L_NEXT);
			7'd62: w = mk(OP_SETRI, R_T0, 4'd1, R_T0, MS_P, C_NONE, NT);
			7'd63: w = mk(OP_CINC, R_T0, R_T0, R_T0, MS_P, C_NOTLAST, L_LOOP);
			// signature r
			7'd64: w = mk(OP_NOP, R_T0, R_T0, R_T0, MS_Q, C_AINF, L_RINF);
			7'd65: w = mk(OP_MOV, R_R, R_AX, R_T0, MS_Q, C_NONE, NT);
			7'd66: w = mk(OP_MOD, R_R, R_R, R_R, MS_Q, C_ALW, L_HASH);
			7'd67: w = mk(OP_QM1, R_R, R_T0, R_T0, MS_Q, C_NONE, NT);
			// hash = 2^message mod q
			7'd68: w = mk(OP_LDK, R_H, 4'd1, R_T0, MS_Q, C_NONE, NT);
			7'd69: w = mk(OP_MOD, R_H, R_H, R_H, MS_Q, C_NONE, NT);
			7'd70: w = mk(OP_ADD, R_BASE, R_H, R_H, MS_Q, C_NONE, NT);
			7'd71: w = mk(OP_CCLR, R_T0, R_T0, R_T0, MS_Q, C_NONE, NT);
			7'd72: w = mk(OP_NOP, R_T0, R_MSG, R_T0, MS_Q, C_BIT0, L_SQ);
			7'd73: w = mk(OP_MUL, R_H, R_H, R_BASE, MS_Q, C_NONE, NT);
			7'd74: w = mk(OP_MUL, R_BASE, R_BASE, R_BASE, MS_Q, C_NONE, NT);
			7'd75: w = mk(OP_CINC, R_T0, R_T0, R_T0, MS_Q, C_NOTLAST, L_PW);
			// signature s
			7'd76: w = mk(OP_MUL, R_T0, R_KEY, R_R, MS_Q, C_NONE, NT);
			7'd77: w = mk(OP_ADD, R_T0, R_H, R_T0, MS_Q, C_NONE, NT);
			7'd78: w = mk(OP_MOD, R_T1, R_K, R_K, MS_Q, C_NONE, NT);
			7'd79: w = mk(OP_INV, R_T1, R_T1, R_T1, MS_Q, C_NONE, NT);
			7'd80: w = mk(OP_MUL, R_S, R_T1, R_T0, MS_Q, C_NONE, NT);
			7'd81: w = mk(OP_DONE, R_T0, R_R, R_S, MS_Q, C_NONE, NT);
			// zero modulus
			7'd82: w = mk(OP_LDK, R_R, 4'd0, R_T0, MS_Q, C_NONE, NT);
			7'd83: w = mk(OP_LDK, R_S, 4'd0, R_T0, MS_Q, C_NONE, NT);
			7'd84: w = mk(OP_DONE, R_T0, R_R, R_S, MS_Q, C_NONE, NT);
			default: w = mk(OP_DONE, R_T0, R_R, R_S, MS_Q, C_NONE, NT);
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/ecsm_rf.sv
`timescale 1ns / 1ps
// Working register file: one write port, two registered read ports.
// Depends on ecsm_pkg for the address width.
module ecsm_rf #(
	parameter int W = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic                       clk,
	input  logic [ecsm_pkg::RF_AW-1:0] ra,
	input  logic [ecsm_pkg::RF_AW-1:0] rb,
	input  logic                       we,
	input  logic [ecsm_pkg::RF_AW-1:0] wa,
	input  logic [W-1:0]               wd,
	output logic [W-1:0]               rda,
	output logic [W-1:0]               rdb
);
	import ecsm_pkg::*;

	logic [W-1:0] mem [2**RF_AW];
	logic [W-1:0] rda_q, rdb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rda_q <= mem[ra];
		rdb_q <= mem[rb];
	end

	assign rda = rda_q;
	assign rdb = rdb_q;
endmodule

FILE: hdl/ecsm_mul.sv
`timescale 1ns / 1ps
// Bit-serial modular multiplier, one operand bit per cycle.
// Depends on ecsm_pkg; operands must be reduced below the modulus.
module ecsm_mul #(
	parameter int W = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] prod
);
	import ecsm_pkg::*;

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q, u_q, v_q, m_q;
	logic [W-1:0]  acc_n, dbl_n;

	function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] md);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[W-1:0];
	endfunction

	assign acc_n = v_q[0] ? addm(acc_q, u_q, m_q) : acc_q;
	assign dbl_n = addm(u_q, u_q, m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			u_q   <= a;
			v_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= acc_n;
			u_q   <= dbl_n;
			v_q   <= v_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

FILE: hdl/ecsm_div.sv
`timescale 1ns / 1ps
// Shift-subtract divider: a single remainder, or the extended-Euclid inverse
// with the Bezout coefficient tracked during each quotient. Depends on ecsm_pkg.
module ecsm_div #(
	parameter int W = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         inv_mode,
	input  logic [W-1:0] a,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] res
);
	import ecsm_pkg::*;

	localparam int CW = $clog2(W);
	localparam int SW = W + 2;
	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_CHK  = 2'd1;
	localparam logic [1:0] D_DIV  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;

	logic [1:0]           st_q;
	logic                 inv_q, done_q;
	logic [W-1:0]         m_q, r0_q, r1_q, rem_q, num_q, res_q;
	logic signed [SW-1:0] s0_q, s1_q, t_q;
	logic [CW-1:0]        j_q;

	logic [W:0]           rr;
	logic                 ge;
	logic [W-1:0]         rem_n;
	logic signed [SW-1:0] t_n;
	logic [SW-1:0]        mag, red;
	logic [W-1:0]         fin_res;

	assign rr    = {rem_q, num_q[W-1]};
	assign ge    = rr >= {1'b0, r1_q};
	assign rem_n = ge ? W'(rr - {1'b0, r1_q}) : W'(rr);
	assign t_n   = ge ? t_q - (s1_q <<< j_q) : t_q;

	always_comb begin
		mag = s0_q[SW-1] ? SW'(-s0_q) : SW'(s0_q);
		red = (mag >= SW'(m_q)) ? mag - SW'(m_q) : mag;
		if (!s0_q[SW-1]) begin
			fin_res = W'(red);
		end else begin
			fin_res = (red == '0) ? '0 : m_q - W'(red);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (start) begin
						st_q <= D_CHK;
					end
				end
				D_CHK: begin
					st_q <= (r1_q == '0) ? D_FIN : D_DIV;
				end
				D_DIV: begin
					if (j_q == '0) begin
						if (inv_q) begin
							st_q <= D_CHK;
						end else begin
							st_q   <= D_IDLE;
							done_q <= 1'b1;
						end
					end
				end
				D_FIN: begin
					st_q   <= D_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (start) begin
					inv_q <= inv_mode;
					m_q   <= m;
					r0_q  <= a;
					r1_q  <= m;
					s0_q  <= SW'(1);
					s1_q  <= '0;
				end
			end
			D_CHK: begin
				rem_q <= '0;
				num_q <= r0_q;
				t_q   <= s0_q;
				j_q   <= CW'(W - 1);
			end
			D_DIV: begin
				rem_q <= rem_n;
				num_q <= num_q << 1;
				t_q   <= t_n;
				j_q   <= j_q - 1'b1;
				if (j_q == '0) begin
					r0_q  <= r1_q;
					r1_q  <= rem_n;
					s0_q  <= s1_q;
					s1_q  <= t_n;
					res_q <= rem_n;
				end
			end
			D_FIN: begin
				res_q <= fin_res;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

FILE: hdl/ecsm_seq.sv
`timescale 1ns / 1ps
// Control-word sequencer: program counter, loop counter and jump logic.
// Depends on ecsm_pkg for the control program and codes.
module ecsm_seq #(
	parameter int W = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic                       retire,
	input  logic                       flag_a,
	input  logic                       flag_r,
	input  logic                       bad_mod,
	input  logic [W-1:0]               rd_a,
	input  logic [W-1:0]               rd_b,
	output ecsm_pkg::uc_t              uw,
	output logic [ecsm_pkg::UC_AW-1:0] pc
);
	import ecsm_pkg::*;

	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	logic [UC_AW-1:0] pc_q;
	logic [CW-1:0]    cnt_q;
	logic             take;

	assign uw = ucode(pc_q);
	assign pc = pc_q;

	always_comb begin
		case (uw.cond)
			C_NONE:    take = 1'b0;
			C_ALW:     take = 1'b1;
			C_BIT0:    take = !rd_a[cnt_q];
			C_AINF:    take = flag_a;
			C_RINF:    take = flag_r;
			C_NE:      take = rd_a != rd_b;
			C_EQZ:     take = rd_a == '0;
			C_NOTLAST: take = cnt_q != LAST;
			C_BADMOD:  take = bad_mod;
			default:   take = 1'b0;
		endcase
	end

	// hold the final step until the next restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			cnt_q <= '0;
		end else if (restart) begin
			pc_q <= '0;
		end else if (retire) begin
			pc_q <= take ? uw.tgt : ((uw.op == OP_DONE) ? pc_q : pc_q + 1'b1);
			if (uw.op == OP_CCLR) begin
				cnt_q <= '0;
			end else if (uw.op == OP_CINC) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end
endmodule

FILE: hdl/ecsm_top_unused_guard.sv
`timescale 1ns / 1ps
// Modular add and subtract unit for reduced operands.
// Depends on ecsm_pkg for the operation codes.
module ecsm_alu #(
	parameter int W = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic [4:0]   op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic [W-1:0] y
);
	import ecsm_pkg::*;

	logic [W:0] s;

	always_comb begin
		s = {1'b0, a} + {1'b0, b};
		if (op == OP_SUB) begin
			y = (a >= b) ? a - b : a + (m - b);
		end else begin
			y = (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : W'(s);
		end
	end
endmodule

FILE: hdl/ecdsa_sign_small_curve.sv
`timescale 1ns / 1ps
// Top level of the small-curve signer; sequencer, register file, ALU,
// multiplier and divider below it. Depends on ecsm_pkg.
//
// Usage:
//  - Request channel in_valid/in_stall/in_req carries base point, key, message
//    and nonce. A request is taken when in_valid is high and in_stall is low;
//    in_stall stays high while a signature is being computed.
//  - Response channel out_valid/out_stall/out_rsp carries sig_r and sig_s. The
//    response sits in an output register, so the next request is taken while
//    it still waits; the program holds at its final step only if a second
//    result is ready before the first one left.
//  - Configuration: cfg_we writes cfg_data into register cfg_index
//    (0 curve_a, 1 field_prime, 2 group_order); write only while idle.
//  - Operation: one request runs one control program. Each step reads, then
//    executes; a modular multiply waits on the bit-serial multiplier, a
//    remainder or an inverse on the divider, an inverse running one Euclid
//    quotient after another with the coefficient tracked alongside.
//  - One request at a time; the next is taken only after the program ends.
//  - Reset clears control state and loads curve_a=1, field_prime=11,
//    group_order=13; no clearing pass is needed.
module ecdsa_sign_small_curve #(
	parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ecsm_pkg::in_req_t           in_req,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ecsm_pkg::out_rsp_t          out_rsp,
	input  logic                        cfg_we,
	input  logic [ecsm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ecsm_pkg::IO_W-1:0]   cfg_data
);
	import ecsm_pkg::*;

	localparam int W = FIELD_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]       state_q;
	in_req_t          req_q;
	out_rsp_t         rsp_q;
	logic             out_valid_q;
	logic             acc_inf_q, run_inf_q;
	logic [W-1:0]     curve_a_q, prime_q, order_q;

	uc_t              uw;
	logic [UC_AW-1:0] pc;
	logic [W-1:0]     rd_a, rd_b, modulus, alu_y, mul_res, div_res, wd;
	logic             mul_done, div_done, multi, is_exec, done_op, done_hold;
	logic             retire, we, start_mul, start_div, accept, bad_mod;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = state_q != ST_IDLE;
	assign is_exec  = state_q == ST_EXEC;
	assign multi    = (uw.op == OP_MUL) || (uw.op == OP_MOD) || (uw.op == OP_INV);
	assign done_op  = uw.op == OP_DONE;
	// hold the final step while the previous response is still stalled
	assign done_hold = done_op && out_valid_q && out_stall;
	assign retire   = (is_exec && !multi && !done_hold)
		|| ((state_q == ST_WAIT) && (mul_done || div_done));
	assign start_mul = is_exec && (uw.op == OP_MUL);
	assign start_div = is_exec && ((uw.op == OP_MOD) || (uw.op == OP_INV));
	assign modulus  = (uw.msel == MS_Q) ? order_q : prime_q;
	assign bad_mod  = (prime_q == '0) || (order_q == '0);

	ecsm_seq #(.W(W)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (accept),
		.retire  (retire),
		.flag_a  (acc_inf_q),
		.flag_r  (run_inf_q),
		.bad_mod (bad_mod),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.uw      (uw),
		.pc      (pc)
	);

	ecsm_rf #(.W(W)) u_rf (
		.clk (clk),
		.ra  (uw.sa),
		.rb  (uw.sb),
		.we  (we),
		.wa  (uw.dst),
		.wd  (wd),
		.rda (rd_a),
		.rdb (rd_b)
	);

	ecsm_alu #(.W(W)) u_alu (
		.op (uw.op),
		.a  (rd_a),
		.b  (rd_b),
		.m  (modulus),
		.y  (alu_y)
	);

	ecsm_mul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_mul),
		.a      (rd_a),
		.b      (rd_b),
		.m      (modulus),
		.done   (mul_done),
		.prod   (mul_res)
	);

	ecsm_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_div),
		.inv_mode (uw.op == OP_INV),
		.a        (rd_a),
		.m        (modulus),
		.done     (div_done),
		.res      (div_res)
	);

	// write-back select
	always_comb begin
		case (uw.op)
			OP_ADD, OP_SUB: wd = alu_y;
			OP_MUL:         wd = mul_res;
			OP_MOD, OP_INV: wd = div_res;
			OP_MOV:         wd = rd_a;
			OP_LDA:         wd = curve_a_q;
			OP_QM1:         wd = order_q - 1'b1;
			OP_LDK:         wd = W'(uw.sa);
			OP_LDI: begin
				case (uw.sa)
					IN_X:    wd = W'(req_q.point_x);
					IN_Y:    wd = W'(req_q.point_y);
					IN_KEY:  wd = W'(req_q.private_key);
					IN_MSG:  wd = W'(req_q.message);
					default: wd = W'(req_q.nonce);
				endcase
			end
			default:        wd = rd_a;
		endcase
	end

	assign we = retire && (uw.op inside {OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_INV,
		OP_MOV, OP_LDA, OP_QM1, OP_LDK, OP_LDI});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_a_q <= W'(1);
			prime_q   <= W'(11);
			order_q   <= W'(13);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CURVE_A:     curve_a_q <= W'(cfg_data);
				CFG_FIELD_PRIME: prime_q   <= W'(cfg_data);
				CFG_GROUP_ORDER: order_q   <= W'(cfg_data);
				default: ;
			endcase
		end
	end

	// step control: idle -> read -> execute (-> wait on a unit) -> next step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			acc_inf_q   <= 1'b0;
			run_inf_q   <= 1'b0;
		end else begin
			// keep a stalled response, raise a new one on the final step
			out_valid_q <= (out_valid_q && out_stall) || (retire && done_op);
			case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (multi) begin
						state_q <= ST_WAIT;
					end else if (retire) begin
						state_q <= done_op ? ST_IDLE : ST_FETCH;
					end
				end
				ST_WAIT:  if (retire) state_q <= ST_FETCH;
				default:  state_q <= ST_IDLE;
			endcase
			if (retire) begin
				case (uw.op)
					OP_SETAI: acc_inf_q <= uw.sa[0];
					OP_SETRI: run_inf_q <= uw.sa[0];
					OP_CPRI:  acc_inf_q <= run_inf_q;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
		end
		if (retire && done_op) begin
			rsp_q.sig_r <= IO_W'(rd_a);
			rsp_q.sig_s <= IO_W'(rd_b);
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = rsp_q;

`ifndef SYNTHESIS
	a_unit_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> state_q == ST_WAIT)
		else $error("arithmetic unit finished outside a wait step");
	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc <= UC_LAST)
		else $error("program counter left the control program");
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(is_exec) && $past(done_op))
		else $error("response raised without a final program step");
`endif
endmodule
